>>> src/xpe_pkg.sv
`timescale 1ns / 1ps
// types, constants and entity tables shared by the predefined entity expander
// no dependencies

package xpe_pkg;

    localparam int ENT_COUNT = 5;
    localparam int BUF_DEPTH = 6;
    localparam int BUF_AW    = 3;
    localparam int OUT_W     = 16;

    typedef logic [7:0] t_ascii;

    localparam t_ascii C_AMP  = 8'h26;
    localparam t_ascii C_SEMI = 8'h3B;

    // entity names, first character in the lowest byte: lt gt amp apos quot
    localparam logic [3:0][7:0] ENT_NAME [ENT_COUNT] = '{
        {8'h00, 8'h00, 8'h74, 8'h6C},
        {8'h00, 8'h00, 8'h74, 8'h67},
        {8'h00, 8'h70, 8'h6D, 8'h61},
        {8'h73, 8'h6F, 8'h70, 8'h61},
        {8'h74, 8'h6F, 8'h75, 8'h71}
    };
    localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4};
    localparam t_ascii ENT_VALUE [ENT_COUNT] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROC,
        ST_FLUSH,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [ENT_COUNT-1:0] cand;
        logic                 prefix;
        logic                 full;
        t_ascii               value;
    } t_match;

    typedef struct packed {
        logic             vld;
        logic [OUT_W-1:0] ch;
        logic             has;
    } t_emit;

    typedef struct packed {
        logic vld;
        logic done;
    } t_fin;

endpackage

>>> src/xpe_match.sv
`timescale 1ns / 1ps
// shared compare unit: checks one character against all entity names at one position
// depends on xpe_pkg

module xpe_match import xpe_pkg::*; #(
    parameter int CHAR_WIDTH = 16
) (
    input  logic [CHAR_WIDTH-1:0] i_char,
    input  logic [2:0]            i_pos,
    input  logic [ENT_COUNT-1:0]  i_cand,
    output t_match                o_res
);

    logic is_semi;

    assign is_semi = (i_char == CHAR_WIDTH'(C_SEMI));

    always_comb begin
        o_res = '0;
        for (int e = 0; e < ENT_COUNT; e++) begin
            // still a candidate if the name has a character here and it matches
            o_res.cand[e] = i_cand[e] && (i_pos < ENT_LEN[e]) &&
                            (i_char == CHAR_WIDTH'(ENT_NAME[e][i_pos[1:0]]));
            if (i_cand[e] && (i_pos == ENT_LEN[e]) && is_semi) begin
                o_res.full  = 1'b1;
                o_res.value = o_res.value | ENT_VALUE[e];
            end
        end
        o_res.prefix = |o_res.cand;
    end

endmodule

>>> src/xpe_out.sv
`timescale 1ns / 1ps
// result staging: one held result plus the output register, tags the last result of a request
// depends on xpe_pkg

module xpe_out import xpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_emit            i_emit,
    input  t_fin             i_fin,
    output logic             o_ready,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OUT_W-1:0] o_out_char,
    output logic             o_has_char,
    output logic             o_run_last,
    output logic             o_value_done
);

    logic             r_hold_v;
    logic [OUT_W-1:0] r_hold_ch;
    logic             r_hold_has;
    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_char;
    logic             r_o_has;
    logic             r_o_last;
    logic             r_o_done;
    logic             w_free;
    logic             w_push;

    assign w_free  = !r_o_valid || !i_out_stall;
    assign o_ready = !r_hold_v || w_free;
    // held result moves on once its successor or the end of the request is known and the output register is free
    assign w_push  = r_hold_v && w_free && (i_emit.vld || i_fin.vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_o_valid <= 1'b1;
            end else if (w_free) begin
                r_o_valid <= 1'b0;
            end
            if (i_emit.vld && o_ready) begin
                r_hold_v <= 1'b1;
            end else if (i_fin.vld && o_ready) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_char <= r_hold_ch;
            r_o_has  <= r_hold_has;
            r_o_last <= i_fin.vld;
            r_o_done <= i_fin.vld && i_fin.done;
        end
        if (i_emit.vld && o_ready) begin
            r_hold_ch  <= i_emit.ch;
            r_hold_has <= i_emit.has;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_char   = r_o_char;
    assign o_has_char   = r_o_has;
    assign o_run_last   = r_o_last;
    assign o_value_done = r_o_done;

endmodule

>>> src/xml_predefined_entity_expander.sv
`timescale 1ns / 1ps
// Expands &lt; &gt; &amp; &apos; &quot; in a character stream, one character per
// request. A small sequencer walks a six-entry character line (held entity run plus
// replayed characters) through one shared compare unit, one character per cycle while
// the output does not stall, and emits at most one result per cycle through a one-deep
// staging register. At the end of a value the flush emits each held character, or an
// end marker if the request emitted nothing else. The input is stalled while a
// request is in work.
// depends on xpe_pkg, xpe_match, xpe_out

module xml_predefined_entity_expander import xpe_pkg::*; #(
    parameter int CHAR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CHAR_WIDTH-1:0] i_in_char,
    input  logic                  i_value_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUT_W-1:0]      o_out_char,
    output logic                  o_has_char,
    output logic                  o_run_last,
    output logic                  o_value_done
);

    t_state                r_state;
    t_state                n_state;
    logic [CHAR_WIDTH-1:0] r_buf [BUF_DEPTH];
    logic [BUF_AW-1:0]     r_len;
    logic [BUF_AW-1:0]     n_len;
    logic [BUF_AW-1:0]     r_pcnt;
    logic [BUF_AW-1:0]     n_pcnt;
    logic [ENT_COUNT-1:0]  r_cand;
    logic [ENT_COUNT-1:0]  n_cand;
    logic                  r_any;
    logic                  n_any;
    logic                  r_end;

    logic                  w_accept;
    logic                  w_empty;
    logic                  w_ready;
    logic                  w_load;
    logic                  w_shift;
    logic                  w_cur_amp;
    logic [CHAR_WIDTH-1:0] w_cur;
    logic [OUT_W-1:0]      w_cur16;
    logic [OUT_W-1:0]      w_head16;
    t_match                w_match;
    t_emit                 w_emit;
    t_fin                  w_fin;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_empty    = (r_pcnt == r_len);
    assign w_cur      = r_buf[r_pcnt];
    assign w_cur_amp  = (w_cur == CHAR_WIDTH'(C_AMP));

    generate
        if (CHAR_WIDTH >= OUT_W) begin : g_narrow
            assign w_cur16  = w_cur[OUT_W-1:0];
            assign w_head16 = r_buf[0][OUT_W-1:0];
        end else begin : g_widen
            assign w_cur16  = {{(OUT_W-CHAR_WIDTH){1'b0}}, w_cur};
            assign w_head16 = {{(OUT_W-CHAR_WIDTH){1'b0}}, r_buf[0]};
        end
    endgenerate

    xpe_match #(
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_match (
        .i_char (w_cur),
        .i_pos  (r_pcnt - 3'd1),
        .i_cand (r_cand),
        .o_res  (w_match)
    );

    xpe_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (w_emit),
        .i_fin        (w_fin),
        .o_ready      (w_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_has_char   (o_has_char),
        .o_run_last   (o_run_last),
        .o_value_done (o_value_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_PROC;
                end
            end
            ST_PROC: begin
                if (w_empty) begin
                    n_state = r_end ? ST_FLUSH : ST_FIN;
                end
            end
            ST_FLUSH: begin
                if ((r_pcnt == 3'd0) && (r_any || w_ready)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_emit  = '0;
        w_fin   = '0;
        w_load  = 1'b0;
        w_shift = 1'b0;
        n_len   = r_len;
        n_pcnt  = r_pcnt;
        n_cand  = r_cand;
        n_any   = r_any;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    n_len  = r_len + 3'd1;
                    n_any  = 1'b0;
                end
            end
            ST_PROC: begin
                if (!w_empty) begin
                    if (r_pcnt == 3'd0) begin
                        if (w_cur_amp) begin
                            n_pcnt = 3'd1;
                            n_cand = '1;
                        end else begin
                            w_emit = '{vld: 1'b1, ch: w_cur16, has: 1'b1};
                            if (w_ready) begin
                                w_shift = 1'b1;
                                n_len   = r_len - 3'd1;
                                n_any   = 1'b1;
                            end
                        end
                    end else if (w_match.full) begin
                        // a completing semicolon is always the last character in the line
                        w_emit = '{vld: 1'b1, ch: {8'h00, w_match.value}, has: 1'b1};
                        if (w_ready) begin
                            n_len  = '0;
                            n_pcnt = '0;
                            n_any  = 1'b1;
                        end
                    end else if (w_match.prefix) begin
                        n_pcnt = r_pcnt + 3'd1;
                        n_cand = w_match.cand;
                    end else begin
                        // broken run: ampersand goes out literally, the rest is rescanned
                        w_emit = '{vld: 1'b1, ch: {8'h00, C_AMP}, has: 1'b1};
                        if (w_ready) begin
                            w_shift = 1'b1;
                            n_len   = r_len - 3'd1;
                            n_pcnt  = '0;
                            n_any   = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (r_pcnt != 3'd0) begin
                    w_emit = '{vld: 1'b1, ch: w_head16, has: 1'b1};
                    if (w_ready) begin
                        w_shift = 1'b1;
                        n_len   = r_len - 3'd1;
                        n_pcnt  = r_pcnt - 3'd1;
                        n_any   = 1'b1;
                    end
                end else if (!r_any) begin
                    // end marker only
                    w_emit = '{vld: 1'b1, ch: '0, has: 1'b0};
                    if (w_ready) begin
                        n_any = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                w_fin = '{vld: 1'b1, done: r_end};
            end
            default: begin
                w_fin = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_pcnt  <= '0;
            r_cand  <= '0;
            r_any   <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pcnt  <= n_pcnt;
            r_cand  <= n_cand;
            r_any   <= n_any;
            if (w_accept) begin
                r_end <= i_value_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf[r_len] <= i_in_char;
        end else if (w_shift) begin
            for (int i = 0; i < BUF_DEPTH - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule
